### hw/rtl/ipv4tx_pkg.sv
`default_nettype none

package ipv4tx_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_SRC_IP = CFG_IDX_W'(3);

  localparam logic [31:0] LOCAL_IP_RST = 32'h0000_0000;
  localparam logic [31:0] MASK_RST     = 32'h0000_0000;
  localparam logic [31:0] GATEWAY_RST  = 32'h0000_0000;
  localparam logic [31:0] LOOP_SRC_RST = 32'h7F00_0001;

  // Header constants
  localparam logic [15:0] VER_IHL_WORD = 16'h4500;
  localparam logic [7:0]  IP_TTL       = 8'd64;
  localparam logic [15:0] HDR_BYTES    = 16'd20;
  localparam logic [7:0]  LOOP_NET     = 8'h7F;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

  // Header word positions
  localparam logic [3:0] WIDX_VER    = 4'd0;
  localparam logic [3:0] WIDX_TLEN   = 4'd1;
  localparam logic [3:0] WIDX_ID     = 4'd2;
  localparam logic [3:0] WIDX_FRAG   = 4'd3;
  localparam logic [3:0] WIDX_TTL    = 4'd4;
  localparam logic [3:0] WIDX_CSUM   = 4'd5;
  localparam logic [3:0] WIDX_SRC_HI = 4'd6;
  localparam logic [3:0] WIDX_SRC_LO = 4'd7;
  localparam logic [3:0] WIDX_DST_HI = 4'd8;
  localparam logic [3:0] WIDX_DST_LO = 4'd9;

  typedef enum logic [1:0] {
    ROUTE_DIRECT  = 2'd0,
    ROUTE_GATEWAY = 2'd1,
    ROUTE_BCAST   = 2'd2,
    ROUTE_LOOP    = 2'd3
  } route_kind_t;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
    logic [31:0] loopback_src_ip;
  } cfg_regs_t;

  typedef struct packed {
    logic [31:0] dest_addr;
    logic [7:0]  proto_num;
    logic [15:0] body_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  route_kind;
    logic [31:0] hop_addr;
    logic [3:0]  word_index;
    logic [15:0] header_word;
    logic        last_word;
  } out_item_t;

  // One classified request, ready for serialization
  typedef struct packed {
    route_kind_t kind;
    logic [31:0] hop;
    logic [31:0] src;
    logic [31:0] dest;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [15:0] csum;
  } desc_t;

endpackage

`default_nettype wire

### hw/rtl/ipv4tx_front.sv
`default_nettype none

module ipv4tx_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  ipv4tx_pkg::cfg_regs_t cfg,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  ipv4tx_pkg::in_item_t  in_data,
  output logic                  q_wr,
  input  wire                   q_ready,
  output ipv4tx_pkg::desc_t     q_wdata
);
  import ipv4tx_pkg::*;

  // Stage 1: route classification
  logic        s1_v_r, s1_v_nxt;
  desc_t       s1_r;
  desc_t       s1_nxt;
  // Stage 2: checksum sum
  logic        s2_v_r, s2_v_nxt;
  desc_t       s2_r;
  logic [18:0] sum_r, sum_nxt;

  logic        s2_free, s1_move, s1_take;
  logic        is_loop, is_bcast, is_gw;
  logic [31:0] bcast_addr;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // Handshake between stages
  assign s2_free  = !s2_v_r || q_ready;
  assign s1_move  = s1_v_r && s2_free;
  assign s1_take  = !s1_v_r || s1_move;
  assign in_stall = !s1_take;
  assign q_wr     = s2_v_r && q_ready;

  // Classification of the incoming request
  always_comb begin
    bcast_addr = (cfg.subnet_mask != '0) ? (cfg.local_ip | ~cfg.subnet_mask) : ALL_ONES;
    is_loop    = (in_data.dest_addr[31:24] == LOOP_NET) ||
                 (in_data.dest_addr == cfg.local_ip);
    is_bcast   = (in_data.dest_addr == ALL_ONES) || (in_data.dest_addr == bcast_addr);
    is_gw      = (cfg.subnet_mask != '0) &&
                 ((in_data.dest_addr & cfg.subnet_mask) != (cfg.local_ip & cfg.subnet_mask)) &&
                 (cfg.gateway_ip != '0);

    s1_nxt         = s1_r;
    s1_nxt.hop     = in_data.dest_addr;
    s1_nxt.src     = cfg.local_ip;
    s1_nxt.dest    = in_data.dest_addr;
    s1_nxt.tot_len = in_data.body_len + HDR_BYTES;
    s1_nxt.proto   = in_data.proto_num;
    s1_nxt.csum    = '0;
    if (is_loop) begin
      s1_nxt.kind = ROUTE_LOOP;
      if (in_data.dest_addr != cfg.local_ip) begin
        s1_nxt.src = cfg.loopback_src_ip;
      end
    end else if (is_bcast) begin
      s1_nxt.kind = ROUTE_BCAST;
    end else if (is_gw) begin
      s1_nxt.kind = ROUTE_GATEWAY;
      s1_nxt.hop  = cfg.gateway_ip;
    end else begin
      s1_nxt.kind = ROUTE_DIRECT;
    end
  end

  // Sum of the seven nonzero header words (checksum word taken as zero)
  assign sum_nxt = 19'(VER_IHL_WORD) + 19'({IP_TTL, s1_r.proto}) + 19'(s1_r.tot_len) +
                   19'(s1_r.src[31:16]) + 19'(s1_r.src[15:0]) +
                   19'(s1_r.dest[31:16]) + 19'(s1_r.dest[15:0]);

  // End-around carry folding and complement on the way into the queue
  always_comb begin
    fold1        = 17'(sum_r[15:0]) + 17'(sum_r[18:16]);
    fold2        = fold1[15:0] + 16'(fold1[16]);
    q_wdata      = s2_r;
    q_wdata.csum = ~fold2;
  end

  assign s1_v_nxt = s1_take ? in_valid : s1_v_r;
  assign s2_v_nxt = s2_free ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      s2_r  <= s1_r;
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ipv4tx_fifo.sv
`default_nettype none

module ipv4tx_fifo (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               wr,
  output logic              wr_ready,
  input  ipv4tx_pkg::desc_t wdata,
  input  wire               rd,
  output logic              rd_valid,
  output ipv4tx_pkg::desc_t rdata
);
  import ipv4tx_pkg::*;

  // Two-entry descriptor queue
  desc_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rdata    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr;
    rd_ptr_nxt = rd_ptr_r ^ rd;
    cnt_nxt    = cnt_r + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ipv4tx_back.sv
`default_nettype none

module ipv4tx_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  output logic                  q_rd,
  input  ipv4tx_pkg::desc_t     q_rdata,
  output logic                  out_valid,
  input  wire                   out_stall,
  output ipv4tx_pkg::out_item_t out_data
);
  import ipv4tx_pkg::*;

  desc_t       cur_r;
  logic        cur_v_r, cur_v_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        out_v_r, out_v_nxt;
  out_item_t   out_r, out_nxt;

  logic        load, is_last, need;
  logic [15:0] word;

  // Output register takes a new beat when empty or being drained
  assign load    = !out_v_r || !out_stall;
  assign is_last = (cnt_r == WIDX_DST_LO);
  assign need    = !cur_v_r || (is_last && load);
  assign q_rd    = need && q_valid;

  // Header word select
  always_comb begin
    unique case (cnt_r)
      WIDX_VER:    word = VER_IHL_WORD;
      WIDX_TLEN:   word = cur_r.tot_len;
      WIDX_ID:     word = '0;
      WIDX_FRAG:   word = '0;
      WIDX_TTL:    word = {IP_TTL, cur_r.proto};
      WIDX_CSUM:   word = cur_r.csum;
      WIDX_SRC_HI: word = cur_r.src[31:16];
      WIDX_SRC_LO: word = cur_r.src[15:0];
      WIDX_DST_HI: word = cur_r.dest[31:16];
      WIDX_DST_LO: word = cur_r.dest[15:0];
      default:     word = '0;
    endcase
  end

  always_comb begin
    out_nxt             = out_r;
    out_nxt.route_kind  = cur_r.kind;
    out_nxt.hop_addr    = cur_r.hop;
    out_nxt.word_index  = cnt_r;
    out_nxt.header_word = word;
    out_nxt.last_word   = is_last;
    out_v_nxt           = load ? cur_v_r : out_v_r;

    // Word counter and descriptor slot
    cur_v_nxt = cur_v_r;
    cnt_nxt   = cnt_r;
    if (q_rd) begin
      cur_v_nxt = 1'b1;
      cnt_nxt   = WIDX_VER;
    end else if (load && cur_v_r) begin
      if (is_last) begin
        cur_v_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      cnt_r   <= WIDX_VER;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_r <= q_rdata;
    end
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### hw/rtl/ipv4_tx_route_and_header_top.sv
`default_nettype none

// Channel   Direction  Handshake         Beat content
// in_       input      valid / stall     dest_addr, proto_num, body_len
// out_      output     valid / stall     route_kind, hop_addr, word_index, header_word, last_word
// cfg_      input      valid / ready     cfg_index (register), cfg_data (32-bit value)
//
// Each request produces ten result beats, one per cycle while out_stall is low; the back part
// loads the next request as its last word is taken, so its word serializer sets the sustained rate.
// A request reaches its first word through front stage 1, front stage 2, queue, slot and output.
// rst_n is synchronous: all valids clear, and the config registers, pointers and counters return to their reset values.
// Input and output stall independently; a two-entry queue separates front and back.
// cfg_ready is always high; writes to an index past the register list are dropped.

module ipv4_tx_route_and_header_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  ipv4tx_pkg::in_item_t                 in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output ipv4tx_pkg::out_item_t                out_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [ipv4tx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [31:0]                           cfg_data
);
  import ipv4tx_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  logic      q_wr, q_ready, q_rd, q_valid;
  desc_t     q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOCAL_IP:    cfg_nxt.local_ip        = cfg_data;
        REG_SUBNET_MASK: cfg_nxt.subnet_mask     = cfg_data;
        REG_GATEWAY_IP:  cfg_nxt.gateway_ip      = cfg_data;
        REG_LOOP_SRC_IP: cfg_nxt.loopback_src_ip = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_ip        <= LOCAL_IP_RST;
      cfg_r.subnet_mask     <= MASK_RST;
      cfg_r.gateway_ip      <= GATEWAY_RST;
      cfg_r.loopback_src_ip <= LOOP_SRC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ipv4tx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_wr     (q_wr),
    .q_ready  (q_ready),
    .q_wdata  (q_wdata)
  );

  ipv4tx_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_ready (q_ready),
    .wdata    (q_wdata),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rdata    (q_rdata)
  );

  ipv4tx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rd      (q_rd),
    .q_rdata   (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### tb/ipv4_header_checker.sv
`timescale 1ns / 1ps

// Watches the config, request and header-word channels, predicts the ten header
// words of every accepted request and compares them with what comes out.
module ipv4_header_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  input  wire                              in_stall,
  input  ipv4tx_pkg::in_item_t             in_data,
  input  wire                              out_valid,
  input  wire                              out_stall,
  input  ipv4tx_pkg::out_item_t            out_data,
  input  wire                              cfg_valid,
  input  wire                              cfg_ready,
  input  wire [ipv4tx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [31:0]                       cfg_data,
  output int                               mismatch_count,
  output int                               words_pending
);
  import ipv4tx_pkg::*;

  localparam int HDR_WORDS  = 10;
  localparam int MAX_REPORT = 10;

  cfg_regs_t iface_regs;
  out_item_t expected_words [$];

  initial begin
    mismatch_count = 0;
    words_pending  = 0;
  end

  // Route the request against the interface and queue its ten header beats
  function automatic void queue_header(input in_item_t req);
    route_kind_t kind;
    logic [31:0] hop;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] bcast;
    logic [31:0] acc;
    logic [15:0] hw [HDR_WORDS];
    out_item_t   beat;
    dst = req.dest_addr;
    hop = dst;
    src = iface_regs.local_ip;
    if (dst[31:24] == LOOP_NET || dst == iface_regs.local_ip) begin
      kind = ROUTE_LOOP;
      if (dst != iface_regs.local_ip) src = iface_regs.loopback_src_ip;
    end else begin
      bcast = (iface_regs.subnet_mask != 32'h0) ?
              (iface_regs.local_ip | ~iface_regs.subnet_mask) : ALL_ONES;
      if (dst == ALL_ONES || dst == bcast) begin
        kind = ROUTE_BCAST;
      end else if (iface_regs.subnet_mask != 32'h0 &&
                   (dst & iface_regs.subnet_mask) !=
                   (iface_regs.local_ip & iface_regs.subnet_mask) &&
                   iface_regs.gateway_ip != 32'h0) begin
        kind = ROUTE_GATEWAY;
        hop  = iface_regs.gateway_ip;
      end else begin
        kind = ROUTE_DIRECT;
      end
    end

    // header words, checksum slot zero while summing
    hw[WIDX_VER]    = VER_IHL_WORD;
    hw[WIDX_TLEN]   = HDR_BYTES + req.body_len;
    hw[WIDX_ID]     = 16'h0000;
    hw[WIDX_FRAG]   = 16'h0000;
    hw[WIDX_TTL]    = {IP_TTL, req.proto_num};
    hw[WIDX_CSUM]   = 16'h0000;
    hw[WIDX_SRC_HI] = src[31:16];
    hw[WIDX_SRC_LO] = src[15:0];
    hw[WIDX_DST_HI] = dst[31:16];
    hw[WIDX_DST_LO] = dst[15:0];

    // one's-complement sum, folded twice
    acc = 32'h0;
    for (int k = 0; k < HDR_WORDS; k++) acc = acc + hw[k];
    acc = {16'h0, acc[15:0]} + (acc >> 16);
    acc = {16'h0, acc[15:0]} + (acc >> 16);
    hw[WIDX_CSUM] = ~acc[15:0];

    for (int k = 0; k < HDR_WORDS; k++) begin
      beat.route_kind  = kind;
      beat.hop_addr    = hop;
      beat.word_index  = 4'(k);
      beat.header_word = hw[k];
      beat.last_word   = (4'(k) == WIDX_DST_LO);
      expected_words.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t exp_beat;
    if (!rst_n) begin
      iface_regs.local_ip        = LOCAL_IP_RST;
      iface_regs.subnet_mask     = MASK_RST;
      iface_regs.gateway_ip      = GATEWAY_RST;
      iface_regs.loopback_src_ip = LOOP_SRC_RST;
      expected_words.delete();
    end else begin
      // register writes; indexes past the list are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOCAL_IP:    iface_regs.local_ip        = cfg_data;
          REG_SUBNET_MASK: iface_regs.subnet_mask     = cfg_data;
          REG_GATEWAY_IP:  iface_regs.gateway_ip      = cfg_data;
          REG_LOOP_SRC_IP: iface_regs.loopback_src_ip = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) queue_header(in_data);

      // compare each result beat with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          if (mismatch_count < MAX_REPORT)
            $display({"[%0t] unexpected header beat: ",
                      "kind=%0d hop=%08h idx=%0d word=%04h last=%0b"},
                     $time, out_data.route_kind, out_data.hop_addr, out_data.word_index,
                     out_data.header_word, out_data.last_word);
          mismatch_count++;
        end else begin
          exp_beat = expected_words.pop_front();
          if (out_data.route_kind  !== exp_beat.route_kind  ||
              out_data.hop_addr    !== exp_beat.hop_addr    ||
              out_data.word_index  !== exp_beat.word_index  ||
              out_data.header_word !== exp_beat.header_word ||
              out_data.last_word   !== exp_beat.last_word) begin
            if (mismatch_count < MAX_REPORT) begin
              $display({"[%0t] header beat mismatch: expected ",
                        "kind=%0d hop=%08h idx=%0d word=%04h last=%0b"},
                       $time, exp_beat.route_kind, exp_beat.hop_addr, exp_beat.word_index,
                       exp_beat.header_word, exp_beat.last_word);
              $display({"[%0t]                       actual   ",
                        "kind=%0d hop=%08h idx=%0d word=%04h last=%0b"},
                       $time, out_data.route_kind, out_data.hop_addr, out_data.word_index,
                       out_data.header_word, out_data.last_word);
            end
            mismatch_count++;
          end
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

### tb/tb_ipv4_tx_route_and_header_top.sv
`timescale 1ns / 1ps

module tb_ipv4_tx_route_and_header_top;
  import ipv4tx_pkg::*;

  localparam int unsigned NUM_REGS   = 4;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          TAIL_CYCLES = 20;
  localparam int          PHASES      = 6;
  localparam int          PHASE_REQS  = 37;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  int mismatch_count;
  int words_pending;
  int quiet_cycles = 0;
  int send_idle_pct = 33;
  int recv_stall_pct = 85;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ipv4_tx_route_and_header_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ipv4_header_checker u_header_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_ipv4_tx_route_and_header_top: errors");
      $finish;
    end
  end

  // one request beat, with random idle cycles ahead of it
  task automatic send_req(input logic [31:0] dest, input logic [7:0] proto,
                          input logic [15:0] plen);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{dest_addr: dest, proto_num: proto, body_len: plen};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // one config beat; valid stays up for back-to-back writes
  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // all four registers plus one write to an unmapped index
  task automatic program_regs(input cfg_regs_t r);
    cfg_beat(REG_LOCAL_IP, r.local_ip);
    cfg_beat(REG_SUBNET_MASK, r.subnet_mask);
    cfg_beat(REG_GATEWAY_IP, r.gateway_ip);
    cfg_beat(REG_LOOP_SRC_IP, r.loopback_src_ip);
    cfg_beat(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)), $urandom());
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every predicted word has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
  endtask

  initial begin
    cfg_regs_t   regs;
    logic [31:0] dest;
    logic [15:0] plen;
    int          pick;
    int          prefix;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: zero address is own address, mask off
    send_req(32'h0000_0000, 8'h00, 16'd0);
    send_req(32'h7F00_0001, 8'hFF, 16'hFFFF);
    send_req(32'h7FFF_FFFF, 8'h06, 16'd65515);
    send_req(32'hFFFF_FFFF, 8'h11, 16'd1);
    send_req(32'h0A00_0001, 8'h01, 16'd100);
    send_req(32'h8000_0000, 8'hAA, 16'h5555);
    drain_results();

    // typical /24 with a gateway
    regs = '{local_ip: 32'hC0A8_010A, subnet_mask: 32'hFFFF_FF00,
             gateway_ip: 32'hC0A8_0101, loopback_src_ip: 32'h7F00_00FE};
    program_regs(regs);
    send_req(32'hC0A8_01FF, 8'h11, 16'd8);
    send_req(32'hC0A8_0114, 8'h06, 16'd1480);
    send_req(32'h0808_0808, 8'h11, 16'd512);
    send_req(32'hC0A8_010A, 8'h01, 16'd64);
    send_req(32'h7F12_3456, 8'h06, 16'hAAAA);
    send_req(32'hFFFF_FFFF, 8'h11, 16'd0);
    send_req(32'hC0A8_0100, 8'h2F, 16'd20);
    send_req(32'h0000_0000, 8'h80, 16'hFFEC);
    drain_results();

    // every register all ones
    regs = '{local_ip: ALL_ONES, subnet_mask: ALL_ONES,
             gateway_ip: ALL_ONES, loopback_src_ip: ALL_ONES};
    program_regs(regs);
    send_req(32'hFFFF_FFFF, 8'h55, 16'h00FF);
    send_req(32'h7F00_0000, 8'h01, 16'hFF00);
    send_req(32'h0000_0000, 8'h06, 16'd65516);
    drain_results();

    // /8 with no gateway
    regs = '{local_ip: 32'h0A00_0001, subnet_mask: 32'hFF00_0000,
             gateway_ip: 32'h0000_0000, loopback_src_ip: 32'h0000_0000};
    program_regs(regs);
    send_req(32'h0B00_0001, 8'h11, 16'd33);
    send_req(32'h0AFF_FFFF, 8'h11, 16'd44);
    send_req(32'h0A00_0001, 8'h06, 16'd55);
    send_req(32'h7F00_0001, 8'h01, 16'd66);
    drain_results();

    // random phases, each under its own interface setting
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 2) begin
        send_idle_pct  = 85;
        recv_stall_pct = 33;
      end else if (phase == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      if (phase == 0) begin
        regs = '0;
      end else begin
        prefix = $urandom_range(0, 32);
        regs.local_ip    = $urandom();
        regs.subnet_mask = ALL_ONES << (32 - prefix);
        if ($urandom_range(0, 3) == 0)
          regs.gateway_ip = 32'h0;
        else
          regs.gateway_ip = (regs.local_ip & regs.subnet_mask) |
                            ($urandom() & ~regs.subnet_mask);
        regs.loopback_src_ip = $urandom();
      end
      program_regs(regs);

      for (int n = 0; n < PHASE_REQS; n++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       dest = regs.local_ip;
          1:       dest = regs.local_ip | ~regs.subnet_mask;
          2:       dest = {LOOP_NET, 24'($urandom())};
          3:       dest = ALL_ONES;
          4, 5:    dest = (regs.local_ip & regs.subnet_mask) |
                          ($urandom() & ~regs.subnet_mask);
          8:       dest = regs.gateway_ip;
          9:       dest = ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom();
          default: dest = $urandom();
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
          0:       plen = 16'd0;
          1:       plen = 16'hFFFF;
          2:       plen = 16'($urandom_range(65510, 65535));
          default: plen = 16'($urandom());
        endcase
        send_req(dest, 8'($urandom_range(0, 255)), plen);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && words_pending == 0)
      $display("tb_ipv4_tx_route_and_header_top: clean");
    else
      $display("tb_ipv4_tx_route_and_header_top: errors");
    $finish;
  end

endmodule
